@@ hw/rtl/text_frame_record_parser_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef TEXT_FRAME_RECORD_PARSER_ASSERT_SVH
`define TEXT_FRAME_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tfrp checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tfrp checker: next-cycle property failed");

`endif

@@ hw/rtl/tfrp_pkg.sv @@
package tfrp_pkg;

	localparam int unsigned RECORDS_MAX_DEF = 32;
	localparam int unsigned NAME_MAX_DEF    = 16;
	localparam int unsigned VALUE_MAX_DEF   = 32;
	localparam int unsigned CNT_W           = 6;
	localparam int unsigned CK_LEN          = 8;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_TAB   = 3'd1,
		CLS_NL    = 3'd2,
		CLS_CR    = 3'd3,
		CLS_COLON = 3'd4
	} byte_class_t;

	typedef enum logic [3:0] {
		KIND_IGNORED    = 4'd0,
		KIND_NAME_CHAR  = 4'd1,
		KIND_VALUE_CHAR = 4'd2,
		KIND_NAME_END   = 4'd3,
		KIND_REC_END    = 4'd4,
		KIND_FRAME_GOOD = 4'd5,
		KIND_CKSUM_BAD  = 4'd6,
		KIND_NAME_OVF   = 4'd7,
		KIND_VALUE_OVF  = 4'd8,
		KIND_REC_OVF    = 4'd9,
		KIND_HEX_START  = 4'd10,
		KIND_HEX_END    = 4'd11,
		KIND_CKSUM_FLD  = 4'd12
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_NAME  = 5'b00010,
		ST_VALUE = 5'b00100,
		ST_HEX   = 5'b01000,
		ST_CKSUM = 5'b10000
	} parse_state_t;

	// Classified byte as it sits in the queue. ck_hit[i] is set when the
	// byte equals character i of "Checksum".
	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
		logic [7:0]  ck_hit;
	} item_t;

	function automatic logic [7:0] ck_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h43;
			3'd1: c = 8'h68;
			3'd2: c = 8'h65;
			3'd3: c = 8'h63;
			3'd4: c = 8'h6B;
			3'd5: c = 8'h73;
			3'd6: c = 8'h75;
			3'd7: c = 8'h6D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/text_frame_record_parser.sv @@
// Text frame record parser: classifies received serial bytes of a text frame.
// Input channel: rx_valid / rx_stall with rx_byte and chunk_last (chunk_last
// does not affect parsing). One byte in gives exactly one classification out.
// Output channel: res_valid / res_stall with kind, char_out, record_index and
// char_pos, all held in an output register.
// The front end classifies each byte and writes it into a two-entry queue; the
// back end pops the queue and runs the parser state machine, one byte per cycle
// while the output is not stalled. A byte passes through its queue entry and
// then the output register before the receiver can take it.
// Throughput: one byte per cycle unless res_stall holds the output.
// With res_valid and res_stall high the output register holds, the back end
// stops and the queue fills; rx_stall rises once both queue entries are full.
// Reset (arst_n low) empties the queue and output register and puts the parser
// in idle with a zero checksum, zero record count and the name match flag set.
module text_frame_record_parser #(
	parameter int unsigned RECORDS_MAX = tfrp_pkg::RECORDS_MAX_DEF,
	parameter int unsigned NAME_MAX    = tfrp_pkg::NAME_MAX_DEF,
	parameter int unsigned VALUE_MAX   = tfrp_pkg::VALUE_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rx_valid,
	output logic                       rx_stall,
	input  logic [7:0]                 rx_byte,
	input  logic                       chunk_last,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [3:0]                 kind,
	output logic [7:0]                 char_out,
	output logic [tfrp_pkg::CNT_W-1:0] record_index,
	output logic [tfrp_pkg::CNT_W-1:0] char_pos
);

	logic            q_valid;
	logic            q_pop;
	tfrp_pkg::item_t q_item;

	tfrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	tfrp_back #(
		.RECORDS_MAX (RECORDS_MAX),
		.NAME_MAX    (NAME_MAX),
		.VALUE_MAX   (VALUE_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.char_out     (char_out),
		.record_index (record_index),
		.char_pos     (char_pos)
	);

endmodule

@@ hw/rtl/tfrp_front.sv @@
module tfrp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rx_valid,
	output logic            rx_stall,
	input  logic [7:0]      rx_byte,
	output logic            q_valid,
	output tfrp_pkg::item_t q_item,
	input  logic            q_pop
);

	tfrp_pkg::item_t cls_item;
	tfrp_pkg::item_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	always_comb begin
		cls_item.data = rx_byte;
		case (rx_byte)
			tfrp_pkg::CH_TAB:   cls_item.cls = tfrp_pkg::CLS_TAB;
			tfrp_pkg::CH_NL:    cls_item.cls = tfrp_pkg::CLS_NL;
			tfrp_pkg::CH_CR:    cls_item.cls = tfrp_pkg::CLS_CR;
			tfrp_pkg::CH_COLON: cls_item.cls = tfrp_pkg::CLS_COLON;
			default:            cls_item.cls = tfrp_pkg::CLS_OTHER;
		endcase
		for (int i = 0; i < 8; i++) begin
			cls_item.ck_hit[i] = (rx_byte == tfrp_pkg::ck_char(3'(i)));
		end
	end

	assign rx_stall = (count_q == 2'd2);
	assign push     = rx_valid && !rx_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/tfrp_back.sv @@
module tfrp_back #(
	parameter int unsigned RECORDS_MAX = tfrp_pkg::RECORDS_MAX_DEF,
	parameter int unsigned NAME_MAX    = tfrp_pkg::NAME_MAX_DEF,
	parameter int unsigned VALUE_MAX   = tfrp_pkg::VALUE_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  tfrp_pkg::item_t            q_item,
	output logic                       q_pop,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [3:0]                 kind,
	output logic [7:0]                 char_out,
	output logic [tfrp_pkg::CNT_W-1:0] record_index,
	output logic [tfrp_pkg::CNT_W-1:0] char_pos
);

	localparam int unsigned W = tfrp_pkg::CNT_W;
	localparam logic [W-1:0] REC_LIM   = W'(RECORDS_MAX);
	localparam logic [W-1:0] NAME_LIM  = W'(NAME_MAX);
	localparam logic [W-1:0] VALUE_LIM = W'(VALUE_MAX);
	localparam logic [W-1:0] CK_POS    = W'(tfrp_pkg::CK_LEN);

	tfrp_pkg::parse_state_t st_q, st_d;
	tfrp_pkg::parse_state_t res_st_q, res_st_d;
	logic [7:0]             sum_q, sum_d;
	logic [W-1:0]           cnt_q, cnt_d;
	logic [W-1:0]           fpos_q, fpos_d;
	logic                   match_q, match_d;
	tfrp_pkg::kind_t        kind_d;
	logic [W-1:0]           pos_d;
	logic [W-1:0]           fpos_inc;
	logic [W-1:0]           cnt_inc;
	logic [7:0]             b;
	logic                   take;

	logic                   out_valid_q;
	tfrp_pkg::kind_t        kind_q;
	logic [7:0]             char_q;
	logic [W-1:0]           rec_q;
	logic [W-1:0]           pos_q;

	assign take     = q_valid && (!out_valid_q || !res_stall);
	assign q_pop    = take;
	assign b        = q_item.data;
	assign fpos_inc = fpos_q + W'(1);
	assign cnt_inc  = cnt_q + W'(1);

	always_comb begin
		st_d     = st_q;
		res_st_d = res_st_q;
		sum_d    = sum_q;
		cnt_d    = cnt_q;
		fpos_d   = fpos_q;
		match_d  = match_q;
		kind_d   = tfrp_pkg::KIND_IGNORED;
		pos_d    = '0;
		case (st_q)
			tfrp_pkg::ST_NAME: begin
				case (q_item.cls)
					tfrp_pkg::CLS_TAB: begin
						sum_d = sum_q + 8'd9;
						if (match_q && fpos_q == CK_POS) begin
							st_d   = tfrp_pkg::ST_CKSUM;
							kind_d = tfrp_pkg::KIND_CKSUM_FLD;
						end else begin
							fpos_d = '0;
							st_d   = tfrp_pkg::ST_VALUE;
							kind_d = tfrp_pkg::KIND_NAME_END;
						end
					end
					tfrp_pkg::CLS_COLON: begin
						res_st_d = tfrp_pkg::ST_NAME;
						st_d     = tfrp_pkg::ST_HEX;
						kind_d   = tfrp_pkg::KIND_HEX_START;
					end
					default: begin
						sum_d = sum_q + b;
						pos_d = fpos_q;
						if (fpos_q >= CK_POS || !q_item.ck_hit[fpos_q[2:0]]) begin
							match_d = 1'b0;
						end
						fpos_d = fpos_inc;
						if (fpos_inc >= NAME_LIM) begin
							st_d   = tfrp_pkg::ST_IDLE;
							kind_d = tfrp_pkg::KIND_NAME_OVF;
						end else begin
							kind_d = tfrp_pkg::KIND_NAME_CHAR;
						end
					end
				endcase
			end
			tfrp_pkg::ST_VALUE: begin
				case (q_item.cls)
					tfrp_pkg::CLS_NL: begin
						sum_d = sum_q + 8'd10;
						cnt_d = cnt_inc;
						if (cnt_inc >= REC_LIM) begin
							st_d   = tfrp_pkg::ST_IDLE;
							kind_d = tfrp_pkg::KIND_REC_OVF;
						end else begin
							fpos_d  = '0;
							match_d = 1'b1;
							st_d    = tfrp_pkg::ST_NAME;
							kind_d  = tfrp_pkg::KIND_REC_END;
						end
					end
					tfrp_pkg::CLS_CR: begin
						sum_d = sum_q + 8'd13;
					end
					tfrp_pkg::CLS_COLON: begin
						res_st_d = tfrp_pkg::ST_VALUE;
						st_d     = tfrp_pkg::ST_HEX;
						kind_d   = tfrp_pkg::KIND_HEX_START;
					end
					default: begin
						sum_d  = sum_q + b;
						pos_d  = fpos_q;
						fpos_d = fpos_inc;
						if (fpos_inc >= VALUE_LIM) begin
							st_d   = tfrp_pkg::ST_IDLE;
							kind_d = tfrp_pkg::KIND_VALUE_OVF;
						end else begin
							kind_d = tfrp_pkg::KIND_VALUE_CHAR;
						end
					end
				endcase
			end
			tfrp_pkg::ST_HEX: begin
				if (q_item.cls == tfrp_pkg::CLS_NL) begin
					st_d   = res_st_q;
					kind_d = tfrp_pkg::KIND_HEX_END;
				end
			end
			tfrp_pkg::ST_CKSUM: begin
				kind_d = (8'(sum_q + b) == 8'd0) ? tfrp_pkg::KIND_FRAME_GOOD
				                                  : tfrp_pkg::KIND_CKSUM_BAD;
				st_d   = tfrp_pkg::ST_IDLE;
			end
			default: begin
				case (q_item.cls)
					tfrp_pkg::CLS_COLON: begin
						res_st_d = tfrp_pkg::ST_IDLE;
						st_d     = tfrp_pkg::ST_HEX;
						kind_d   = tfrp_pkg::KIND_HEX_START;
					end
					tfrp_pkg::CLS_NL: begin
						sum_d   = sum_q + 8'd10;
						cnt_d   = '0;
						fpos_d  = '0;
						match_d = 1'b1;
						st_d    = tfrp_pkg::ST_NAME;
						kind_d  = tfrp_pkg::KIND_REC_END;
					end
					tfrp_pkg::CLS_CR: begin
						sum_d = 8'd13;
					end
					default: begin
						sum_d = sum_q;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tfrp_pkg::ST_IDLE;
			res_st_q    <= tfrp_pkg::ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			fpos_q      <= '0;
			match_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				st_q        <= st_d;
				res_st_q    <= res_st_d;
				sum_q       <= sum_d;
				cnt_q       <= cnt_d;
				fpos_q      <= fpos_d;
				match_q     <= match_d;
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= kind_d;
			char_q <= b;
			rec_q  <= cnt_d;
			pos_q  <= pos_d;
		end
	end

	assign res_valid    = out_valid_q;
	assign kind         = kind_q;
	assign char_out     = char_q;
	assign record_index = rec_q;
	assign char_pos     = pos_q;

endmodule

@@ hw/rtl/tfrp_checker.sv @@
`include "text_frame_record_parser_assert.svh"

module tfrp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_stall,
	input logic [3:0]                 kind,
	input logic [7:0]                 char_out,
	input logic [tfrp_pkg::CNT_W-1:0] char_pos
);

	`TFRP_ASSERT_NOW(a_kind_range, clk, arst_n, res_valid,
		kind <= tfrp_pkg::KIND_CKSUM_FLD)

	`TFRP_ASSERT_NOW(a_pos_zero, clk, arst_n,
		res_valid && !(kind == tfrp_pkg::KIND_NAME_CHAR ||
			kind == tfrp_pkg::KIND_VALUE_CHAR ||
			kind == tfrp_pkg::KIND_NAME_OVF || kind == tfrp_pkg::KIND_VALUE_OVF),
		char_pos == '0)

	`TFRP_ASSERT_NOW(a_pos_bound, clk, arst_n, res_valid, char_pos < 6'd32)

	`TFRP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(char_out) && $stable(kind))

endmodule

bind text_frame_record_parser tfrp_checker u_tfrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.kind      (kind),
	.char_out  (char_out),
	.char_pos  (char_pos)
);

@@ bench/text_frame_record_parser_checker.sv @@
module text_frame_record_parser_checker
	import tfrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	input  logic             rx_stall,
	input  logic [7:0]       rx_byte,
	input  logic             res_valid,
	input  logic             res_stall,
	input  logic [3:0]       kind,
	input  logic [7:0]       char_out,
	input  logic [CNT_W-1:0] record_index,
	input  logic [CNT_W-1:0] char_pos,
	output int               fail_count,
	output int               pending
);

	localparam logic [8*CK_LEN-1:0] CK_WORD = "Checksum";
	localparam int PRINT_MAX = 40;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       ch;
		logic [CNT_W-1:0] rec;
		logic [CNT_W-1:0] pos;
	} byte_class_rec_t;

	parse_state_t     state;
	parse_state_t     resume;
	logic [7:0]       sum;
	logic [CNT_W-1:0] rec_count;
	logic [CNT_W-1:0] fpos;
	logic             ck_match;

	byte_class_rec_t expected_classes[$];

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_MAX)
			$display("mismatch: %s", msg);
		fail_count++;
	endtask

	task automatic start_name();
		fpos = '0;
		ck_match = 1'b1;
		state = ST_NAME;
	endtask

	task automatic classify_byte(input logic [7:0] b, output byte_class_rec_t r);
		logic [CNT_W-1:0] p;
		kind_t            k;
		p = '0;
		k = KIND_IGNORED;
		case (state)
			ST_NAME: begin
				if (b == CH_TAB) begin
					sum = sum + CH_TAB;
					if (ck_match && fpos == CK_LEN) begin
						state = ST_CKSUM;
						k = KIND_CKSUM_FLD;
					end else begin
						fpos = '0;
						state = ST_VALUE;
						k = KIND_NAME_END;
					end
				end else if (b == CH_COLON) begin
					resume = ST_NAME;
					state = ST_HEX;
					k = KIND_HEX_START;
				end else begin
					sum = sum + b;
					p = fpos;
					if (fpos >= CK_LEN || CK_WORD[8*(CK_LEN-1-fpos[2:0]) +: 8] != b)
						ck_match = 1'b0;
					fpos = fpos + 1'b1;
					if (fpos >= NAME_MAX_DEF) begin
						state = ST_IDLE;
						k = KIND_NAME_OVF;
					end else begin
						k = KIND_NAME_CHAR;
					end
				end
			end
			ST_VALUE: begin
				if (b == CH_NL) begin
					sum = sum + CH_NL;
					rec_count = rec_count + 1'b1;
					if (rec_count >= RECORDS_MAX_DEF) begin
						state = ST_IDLE;
						k = KIND_REC_OVF;
					end else begin
						start_name();
						k = KIND_REC_END;
					end
				end else if (b == CH_CR) begin
					sum = sum + CH_CR;
				end else if (b == CH_COLON) begin
					resume = ST_VALUE;
					state = ST_HEX;
					k = KIND_HEX_START;
				end else begin
					sum = sum + b;
					p = fpos;
					fpos = fpos + 1'b1;
					if (fpos >= VALUE_MAX_DEF) begin
						state = ST_IDLE;
						k = KIND_VALUE_OVF;
					end else begin
						k = KIND_VALUE_CHAR;
					end
				end
			end
			ST_HEX: begin
				if (b == CH_NL) begin
					state = resume;
					k = KIND_HEX_END;
				end
			end
			ST_CKSUM: begin
				k = (8'(sum + b) == 8'd0) ? KIND_FRAME_GOOD : KIND_CKSUM_BAD;
				state = ST_IDLE;
			end
			default: begin
				if (b == CH_COLON) begin
					resume = ST_IDLE;
					state = ST_HEX;
					k = KIND_HEX_START;
				end else if (b == CH_NL) begin
					sum = sum + CH_NL;
					rec_count = '0;
					start_name();
					k = KIND_REC_END;
				end else if (b == CH_CR) begin
					sum = CH_CR;
				end
			end
		endcase
		r = '{k, b, rec_count, p};
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		byte_class_rec_t e;
		if (!arst_n) begin
			state = ST_IDLE;
			resume = ST_IDLE;
			sum = '0;
			rec_count = '0;
			fpos = '0;
			ck_match = 1'b1;
			expected_classes.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_classes.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with nothing expected", kind));
				end else begin
					e = expected_classes.pop_front();
					if (kind !== e.kind)
						report_mismatch($sformatf("kind %0d, expected %0d (byte %h)",
							kind, e.kind, e.ch));
					if (char_out !== e.ch)
						report_mismatch($sformatf("char_out %h, expected %h", char_out, e.ch));
					if (record_index !== e.rec)
						report_mismatch($sformatf("record_index %0d, expected %0d (byte %h)",
							record_index, e.rec, e.ch));
					if (char_pos !== e.pos)
						report_mismatch($sformatf("char_pos %0d, expected %0d (byte %h)",
							char_pos, e.pos, e.ch));
				end
			end
			if (rx_valid && !rx_stall) begin
				classify_byte(rx_byte, e);
				expected_classes.push_back(e);
			end
		end
		pending = expected_classes.size();
	end

endmodule

@@ bench/tb_text_frame_record_parser.sv @@
module tb_text_frame_record_parser;
	import tfrp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             rx_valid   = 1'b0;
	logic [7:0]       rx_byte    = 8'h00;
	logic             chunk_last = 1'b0;
	logic             res_stall  = 1'b0;
	logic             rx_stall;
	logic             res_valid;
	logic [3:0]       kind;
	logic [7:0]       char_out;
	logic [CNT_W-1:0] record_index;
	logic [CNT_W-1:0] char_pos;

	int         fail_count;
	int         pending;
	int         cycle_count   = 0;
	int         sent_items    = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       hold_req      = 1'b0;
	logic [7:0] frame_sum;

	always #2 clk = ~clk;

	text_frame_record_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.chunk_last   (chunk_last),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.char_out     (char_out),
		.record_index (record_index),
		.char_pos     (char_pos)
	);

	text_frame_record_parser_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.char_out     (char_out),
		.record_index (record_index),
		.char_pos     (char_pos),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_item(input logic [7:0] b);
		logic stalled;
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid   <= 1'b1;
		rx_byte    <= b;
		chunk_last <= 1'($urandom_range(1));
		do begin
			@(negedge clk);
			stalled = rx_stall;
			@(posedge clk);
		end while (stalled);
		sent_items++;
	endtask

	task automatic send_counted(input logic [7:0] b);
		frame_sum = frame_sum + b;
		send_item(b);
	endtask

	// binary-register frame: colon, content without newline, newline
	task automatic send_hex();
		logic [7:0] c;
		send_item(CH_COLON);
		repeat ($urandom_range(6)) begin
			do c = 8'($urandom_range(255)); while (c == CH_NL);
			send_item(c);
		end
		send_item(CH_NL);
	endtask

	function automatic logic [7:0] field_byte(input bit wide, input bit is_name);
		logic [7:0] c;
		do begin
			c = wide ? 8'($urandom_range(255)) : 8'($urandom_range(8'h20, 8'h7E));
		end while (c == CH_COLON || (is_name && c == CH_TAB) || (!is_name && c == CH_NL));
		return c;
	endfunction

	task automatic send_frame();
		logic [7:0] name_q[$];
		logic [7:0] c;
		string      nm;
		int         nrec;
		int         vlen;
		bit         wide;
		frame_sum = 8'h00;
		if ($urandom_range(7) != 0)
			send_counted(CH_CR);
		send_counted(CH_NL);
		nrec = ($urandom_range(29) == 0) ?
			$urandom_range(RECORDS_MAX_DEF - 1, RECORDS_MAX_DEF + 1) : $urandom_range(5);
		for (int r = 0; r < nrec; r++) begin
			wide = ($urandom_range(3) == 0);
			name_q.delete();
			nm = "";
			case ($urandom_range(19))
				0: nm = "Checksu";
				1: nm = "Checksumm";
				2: nm = "Checksun";
				3: nm = "checksum";
				default: begin
					repeat (($urandom_range(19) == 0) ?
						$urandom_range(NAME_MAX_DEF - 1, NAME_MAX_DEF + 1) :
						$urandom_range(10))
						name_q.push_back(field_byte(wide, 1'b1));
				end
			endcase
			for (int i = 0; i < nm.len(); i++)
				name_q.push_back(nm[i]);
			foreach (name_q[i]) begin
				if ($urandom_range(24) == 0)
					send_hex();
				send_counted(name_q[i]);
			end
			if (name_q.size() >= NAME_MAX_DEF)
				return;
			send_counted(CH_TAB);
			vlen = ($urandom_range(19) == 0) ?
				$urandom_range(VALUE_MAX_DEF - 1, VALUE_MAX_DEF + 1) : $urandom_range(12);
			for (int v = 0; v < vlen; v++) begin
				if ($urandom_range(24) == 0)
					send_hex();
				send_counted(field_byte(wide, 1'b0));
			end
			if (vlen >= VALUE_MAX_DEF)
				return;
			send_counted(CH_NL);
			if (r + 1 >= RECORDS_MAX_DEF)
				return;
		end
		nm = "Checksum";
		for (int i = 0; i < nm.len(); i++)
			send_counted(nm[i]);
		send_counted(CH_TAB);
		c = 8'h00 - frame_sum;
		if ($urandom_range(5) == 0)
			c = c + 8'($urandom_range(1, 255));
		send_item(c);
	endtask

	task automatic run_phase(input int target);
		while (sent_items < target) begin
			case ($urandom_range(9))
				0: repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(255)));
				1: send_hex();
				default: send_frame();
			endcase
		end
	endtask

	initial begin : stimulus
		logic [7:0] directed_q[$];
		directed_q = '{8'h00, CH_COLON, 8'hFF, CH_NL, CH_CR, CH_NL, "C", CH_COLON, CH_NL,
			CH_TAB, 8'hFF, CH_CR, CH_COLON, CH_NL, CH_NL,
			"C", "h", "e", "c", "k", "s", "u", "m", CH_TAB, CH_COLON};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_q[i])
			send_item(directed_q[i]);

		send_idle_pct = 28;
		recv_idle_pct = 61;
		hold_req = 1'b1;
		run_phase(525);

		send_idle_pct = 61;
		recv_idle_pct = 28;
		run_phase(1025);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_phase(1525);

		rx_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
